[design/kvc_pkg.sv]
// kvc_pkg: word types, register indexes, event codes and the volume-to-duty
// helper shared by the knob volume controller.
// No dependencies.
`default_nettype none

package kvc_pkg;

	localparam int unsigned TIMER_BITS_DEFAULT = 16;
	localparam int unsigned CFG_INDEX_BITS     = 3;
	localparam int unsigned CFG_DATA_BITS      = 16;

	localparam logic [6:0]  VOLUME_MAX          = 7'd100;
	localparam logic [6:0]  VOLUME_RESET        = 7'd50;
	localparam logic [7:0]  DUTY_RESET          = 8'd127;
	localparam logic [15:0] HOLD_TICKS_RESET    = 16'd500;
	localparam logic [15:0] DCLICK_TICKS_RESET  = 16'd500;
	localparam logic [6:0]  HOLD_VOLUME_RESET   = 7'd50;
	localparam logic [6:0]  DCLICK_VOLUME_RESET = 7'd100;
	localparam logic [7:0]  LED_ON_DUTY_RESET   = 8'd128;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DCLICK_TICKS  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_VOLUME   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DCLICK_VOLUME = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LED_ON_DUTY   = 3'd4;

	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_UP   = 2'd1,
		ROT_DOWN = 2'd2
	} rotate_t;

	typedef enum logic [1:0] {
		GEST_NONE   = 2'd0,
		GEST_SINGLE = 2'd1,
		GEST_DOUBLE = 2'd2,
		GEST_HOLD   = 2'd3
	} gesture_t;

	typedef struct packed {
		logic enc_a;
		logic enc_b;
		logic button_n;
	} tick_t;

	typedef struct packed {
		logic [6:0] volume_level;
		logic [7:0] led_duty;
		logic [1:0] rotate_event;
		logic [1:0] gesture_event;
	} result_t;

	// clamp a register volume to the legal range
	function automatic logic [6:0] sat_volume(input logic [6:0] v);
		return (v > VOLUME_MAX) ? VOLUME_MAX : v;
	endfunction

	// floor(v*255/100) for v <= 100: v*255 by shift-subtract, /100 as *5243 >> 19
	function automatic logic [7:0] duty_of(input logic [6:0] v);
		logic [14:0] x;
		logic [27:0] p;
		x = {v, 8'd0} - {8'd0, v};
		p = {13'd0, x} * 28'd5243;
		return p[26:19];
	endfunction

endpackage

`default_nettype wire

[design/knob_volume_controller.sv]
// knob_volume_controller: rotary knob volume control with click, double click
// and hold detection on the push button. Depends on kvc_pkg.
//
//   channel  | direction | handshake                     | word
//   tick     | in        | tick_valid / tick_stall       | kvc_pkg::tick_t
//   result   | out       | result_valid / result_stall   | kvc_pkg::result_t
//   cfg      | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One tick word per cycle while tick_stall is low. The whole update is one pass of
// logic from the state registers and the tick into the state and the result or skid
// register. A two-entry output (result plus skid) keeps tick_stall low until two
// results are waiting. arst_n sets all state but the result and skid words to its
// reset values at once; there is no clearing pass. cfg_ready is always high.
`default_nettype none

module knob_volume_controller #(
	parameter int unsigned TIMER_BITS = kvc_pkg::TIMER_BITS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                tick_valid,
	output logic                                     tick_stall,
	input  wire kvc_pkg::tick_t                      tick,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output kvc_pkg::result_t                         result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [kvc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [kvc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int unsigned CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// configuration
	logic [15:0] hold_ticks_q;
	logic [15:0] dclick_ticks_q;
	logic [6:0]  hold_volume_q;
	logic [6:0]  dclick_volume_q;
	logic [7:0]  led_on_duty_q;

	// tracking state
	logic                  prev_a_q;
	logic                  prev_btn_q;
	logic [1:0]            clicks_q;
	logic [TIMER_BITS-1:0] since_press_q;
	logic [TIMER_BITS-1:0] held_q;
	logic                  hold_done_q;
	logic [6:0]            volume_q;
	logic [7:0]            duty_q;

	// output buffer
	logic             out_valid_q;
	kvc_pkg::result_t out_q;
	logic             skid_valid_q;
	kvc_pkg::result_t skid_q;

	logic                  accept;
	logic                  out_take;
	logic                  knob_step;
	logic [6:0]            vol_knob;
	logic                  vol_set;
	logic [6:0]            vol_gest;
	logic [6:0]            vol_nx;
	logic [7:0]            duty_knob;
	logic [7:0]            duty_nx;
	logic                  press;
	logic [1:0]            clicks_nx;
	logic [TIMER_BITS-1:0] since_nx;
	logic [TIMER_BITS-1:0] held_nx;
	logic                  hold_done_nx;
	kvc_pkg::rotate_t      rot;
	kvc_pkg::gesture_t     gest;
	kvc_pkg::result_t      res;

	assign cfg_ready    = 1'b1;
	assign tick_stall   = skid_valid_q;
	assign accept       = tick_valid && !skid_valid_q;
	assign out_take     = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		rot       = kvc_pkg::ROT_NONE;
		knob_step = prev_a_q && !tick.enc_a;
		vol_knob  = volume_q;
		if (knob_step) begin
			if (tick.enc_b) begin
				vol_knob = (volume_q < kvc_pkg::VOLUME_MAX) ? volume_q + 7'd1
					: kvc_pkg::VOLUME_MAX;
				rot      = kvc_pkg::ROT_UP;
			end else begin
				vol_knob = (volume_q > 7'd0) ? volume_q - 7'd1 : 7'd0;
				rot      = kvc_pkg::ROT_DOWN;
			end
		end

		press        = prev_btn_q && !tick.button_n;
		clicks_nx    = clicks_q;
		held_nx      = held_q;
		hold_done_nx = hold_done_q;
		if (press) begin
			clicks_nx    = (clicks_q == 2'd1 && CW'(since_press_q) < CW'(dclick_ticks_q))
				? 2'd2 : 2'd1;
			since_nx     = '0;
			held_nx      = '0;
			hold_done_nx = 1'b0;
		end else begin
			since_nx = (since_press_q == TIMER_MAX) ? TIMER_MAX : since_press_q + 1'b1;
		end

		gest     = kvc_pkg::GEST_NONE;
		vol_set  = 1'b0;
		vol_gest = vol_knob;
		if (!tick.button_n) begin
			if (!hold_done_nx) begin
				held_nx = (held_nx == TIMER_MAX) ? TIMER_MAX : held_nx + 1'b1;
				if (CW'(held_nx) >= CW'(hold_ticks_q)) begin
					hold_done_nx = 1'b1;
					clicks_nx    = 2'd0;
					vol_set      = 1'b1;
					vol_gest     = kvc_pkg::sat_volume(hold_volume_q);
					gest         = kvc_pkg::GEST_HOLD;
				end
			end
		end else begin
			hold_done_nx = 1'b0;
			if (clicks_nx != 2'd0 && CW'(since_nx) > CW'(dclick_ticks_q)) begin
				if (clicks_nx == 2'd1) begin
					gest = kvc_pkg::GEST_SINGLE;
				end else begin
					vol_set  = 1'b1;
					vol_gest = kvc_pkg::sat_volume(dclick_volume_q);
					gest     = kvc_pkg::GEST_DOUBLE;
				end
				clicks_nx = 2'd0;
			end
		end

		vol_nx    = vol_set ? vol_gest : vol_knob;
		duty_knob = (knob_step || vol_set) ? kvc_pkg::duty_of(vol_nx) : duty_q;
		// single click toggles the LED between off and its on level
		if (gest == kvc_pkg::GEST_SINGLE) begin
			duty_nx = (duty_knob != 8'd0) ? 8'd0 : led_on_duty_q;
		end else begin
			duty_nx = duty_knob;
		end

		res.volume_level  = vol_nx;
		res.led_duty      = duty_nx;
		res.rotate_event  = rot;
		res.gesture_event = gest;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q    <= kvc_pkg::HOLD_TICKS_RESET;
			dclick_ticks_q  <= kvc_pkg::DCLICK_TICKS_RESET;
			hold_volume_q   <= kvc_pkg::HOLD_VOLUME_RESET;
			dclick_volume_q <= kvc_pkg::DCLICK_VOLUME_RESET;
			led_on_duty_q   <= kvc_pkg::LED_ON_DUTY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kvc_pkg::REG_HOLD_TICKS:    hold_ticks_q    <= cfg_data;
				kvc_pkg::REG_DCLICK_TICKS:  dclick_ticks_q  <= cfg_data;
				kvc_pkg::REG_HOLD_VOLUME:   hold_volume_q   <= cfg_data[6:0];
				kvc_pkg::REG_DCLICK_VOLUME: dclick_volume_q <= cfg_data[6:0];
				kvc_pkg::REG_LED_ON_DUTY:   led_on_duty_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q      <= 1'b1;
			prev_btn_q    <= 1'b1;
			clicks_q      <= 2'd0;
			since_press_q <= '0;
			held_q        <= '0;
			hold_done_q   <= 1'b0;
			volume_q      <= kvc_pkg::VOLUME_RESET;
			duty_q        <= kvc_pkg::DUTY_RESET;
		end else if (accept) begin
			prev_a_q      <= tick.enc_a;
			prev_btn_q    <= tick.button_n;
			clicks_q      <= clicks_nx;
			since_press_q <= since_nx;
			held_q        <= held_nx;
			hold_done_q   <= hold_done_nx;
			volume_q      <= vol_nx;
			duty_q        <= duty_nx;
		end
	end

	// result register with a skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= skid_valid_q && accept;
		end else begin
			skid_valid_q <= skid_valid_q || accept;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (accept) begin
					skid_q <= res;
				end
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

endmodule

`default_nettype wire
